// ===== hw/rtl/walc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// walc_pkg
// Shared types, register indexes and the microcode table of the wall-avoid
// lead-lag controller.
// ============================================================================
package walc_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_A0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CONTROL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FREE    = 3'd4;

    // Fixed register widths and fixed-point positions.
    localparam int A0_W      = 16;
    localparam int COEF_W    = 24;
    localparam int MAXC_W    = 15;
    localparam int INV_W     = 20;
    localparam int FRAC_W    = 20;   // fraction bits of the filter sum and ratio
    localparam int FB_SHIFT  = 6;    // Q2.14 times the Q16.0 angle lines up with Q.20 after this
    localparam int CAP_BIT   = 62;   // magnitude cap of the scaled setpoint product

    // Axis select.
    localparam logic AXIS_PITCH = 1'b0;
    localparam logic AXIS_ROLL  = 1'b1;

    typedef struct packed {
        logic [A0_W-1:0]   a0;
        logic [COEF_W-1:0] b0;
        logic [COEF_W-1:0] b1;
        logic [MAXC_W-1:0] max_ctl;
        logic [INV_W-1:0]  inv;
    } cfg_t;

    // Multiplier operand selects.
    typedef enum logic [2:0] {
        OPA_A0   = 3'd0,
        OPA_B1   = 3'd1,
        OPA_B0   = 3'd2,
        OPA_ABSD = 3'd3,
        OPA_MAG  = 3'd4
    } opa_t;

    typedef enum logic [2:0] {
        OPB_UPREV = 3'd0,
        OPB_ERR   = 3'd1,
        OPB_EPREV = 3'd2,
        OPB_INV   = 3'd3,
        OPB_MLO   = 3'd4,
        OPB_MHI   = 3'd5
    } opb_t;

    typedef enum logic [1:0] {
        ACC_HOLD     = 2'd0,
        ACC_LOAD     = 2'd1,
        ACC_LOAD_NEG = 2'd2,
        ACC_ADD      = 2'd3
    } acc_op_t;

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_SIX  = 2'd1,
        SH_HALF = 2'd2
    } shift_t;

    typedef enum logic {
        JMP_NEXT = 1'b0,
        JMP_AXIS = 1'b1
    } jump_t;

    // One control word of the sequencer.
    typedef struct packed {
        opa_t    opa;
        opb_t    opb;
        acc_op_t acc_op;
        shift_t  sh;
        logic    fin;    // round and clamp the filter sum, save state, load the ratio
        logic    mag;    // cap and round the scaled setpoint magnitude
        logic    sum;    // add setpoint to filter output and saturate
        jump_t   jump;
    } ctrl_t;

    localparam int STEP_W = 3;

    localparam ctrl_t CTRL_NOP = '{OPA_A0, OPB_UPREV, ACC_HOLD, SH_NONE,
                                   1'b0, 1'b0, 1'b0, JMP_NEXT};

    // Microcode for one axis; the last step loops to the second axis or ends.
    function automatic ctrl_t ucode_word(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = CTRL_NOP;
        case (step)
            3'd0:
            begin
                w.opa = OPA_A0;   w.opb = OPB_UPREV; w.acc_op = ACC_LOAD_NEG; w.sh = SH_SIX;
            end
            3'd1:
            begin
                w.opa = OPA_B1;   w.opb = OPB_ERR;   w.acc_op = ACC_ADD;
            end
            3'd2:
            begin
                w.opa = OPA_B0;   w.opb = OPB_EPREV; w.acc_op = ACC_ADD;
            end
            3'd3:
            begin
                w.opa = OPA_ABSD; w.opb = OPB_INV;   w.fin = 1'b1;
            end
            3'd4:
            begin
                w.opa = OPA_MAG;  w.opb = OPB_MLO;   w.acc_op = ACC_LOAD;
            end
            3'd5:
            begin
                w.opa = OPA_MAG;  w.opb = OPB_MHI;   w.acc_op = ACC_ADD; w.sh = SH_HALF;
            end
            3'd6:
            begin
                w.mag = 1'b1;
            end
            3'd7:
            begin
                w.sum = 1'b1;     w.jump = JMP_AXIS;
            end
            default:
            begin
                w = CTRL_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/walc_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// walc_datapath
// Shared multiplier, accumulator and per-axis state, driven one control word
// per cycle by the sequencer in the top level.
// ============================================================================
module walc_datapath
    import walc_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16,
    parameter int DIST_WIDTH  = 13
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctrl_t                         ctrl,
    input  logic                          axis,
    input  cfg_t                          cfg,
    input  logic signed [ANGLE_WIDTH-1:0] sp,
    input  logic signed [DIST_WIDTH-1:0]  dist_cm,
    output logic        [ANGLE_WIDTH-1:0] pitch_res,
    output logic        [ANGLE_WIDTH-1:0] roll_res
);

    localparam int AW     = ANGLE_WIDTH;
    localparam int DW     = DIST_WIDTH;
    localparam int OPW_AD = (AW > DW) ? AW + 1 : DW + 1;
    localparam int OPW    = (OPW_AD > COEF_W + 1) ? OPW_AD : COEF_W + 1;
    localparam int PW     = 2 * OPW;
    localparam int ML     = OPW - 1;           // bits of the low ratio half
    localparam int MEXT_W = 2 * ML;
    localparam int MW     = DW + INV_W;        // distance ratio width
    localparam int ACCW   = AW + DW + 22;
    localparam int FW     = ACCW - FRAC_W;
    localparam int SATW   = (ACCW > 64) ? ACCW : 64;
    localparam int MGW    = SATW - FRAC_W;
    localparam int SUMW   = MGW + 2;

    localparam logic [FW-1:0]   AMAX_F  = (FW'(1) << (AW - 1)) - FW'(1);
    localparam logic [SUMW-1:0] AMAX_S  = (SUMW'(1) << (AW - 1)) - SUMW'(1);
    localparam logic [SUMW-1:0] AMIN_S  = ~AMAX_S;
    localparam logic [AW-1:0]   AMAX_A  = {1'b0, {(AW - 1){1'b1}}};
    localparam logic [AW-1:0]   AMIN_A  = {1'b1, {(AW - 1){1'b0}}};
    localparam logic [SATW-1:0] MAG_CAP = SATW'(1) << CAP_BIT;

    logic signed [OPW-1:0]  opa;
    logic signed [OPW-1:0]  opb;
    logic signed [PW-1:0]   prod;
    logic signed [ACCW-1:0] term;
    logic signed [ACCW-1:0] term_sh;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [ACCW-1:0] acc_rnd;
    logic        [DW-1:0]   dist_abs;
    logic        [AW-1:0]   sp_abs;
    logic        [MW-1:0]   m_reg;
    logic        [MEXT_W-1:0] m_ext;
    logic signed [FW-1:0]   flt;
    logic        [FW-1:0]   max_f;
    logic signed [FW-1:0]   lim;
    logic signed [FW-1:0]   neg_lim;
    logic signed [FW-1:0]   u_clamp;
    logic signed [AW-1:0]   u_reg;
    logic signed [AW-1:0]   prev_out_reg [2];
    logic signed [DW-1:0]   prev_err_reg [2];
    logic        [SATW-1:0] acc_u;
    logic        [SATW-1:0] mag_sat;
    logic        [SATW-1:0] mag_rnd;
    logic        [MGW-1:0]  mag_reg;
    logic signed [SUMW-1:0] mag_ext;
    logic signed [SUMW-1:0] scaled;
    logic signed [SUMW-1:0] sum_full;
    logic                   scale_en;
    logic        [AW-1:0]   sum_sat;
    logic        [AW-1:0]   res_reg [2];

    // Magnitudes of the distance and the setpoint.
    assign dist_abs = dist_cm[DW-1] ? DW'(-dist_cm) : DW'(dist_cm);
    assign sp_abs   = sp[AW-1] ? AW'(-sp) : AW'(sp);
    assign m_ext    = MEXT_W'(m_reg);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (ctrl.opa)
            OPA_A0:   opa = OPW'($signed(cfg.a0));
            OPA_B1:   opa = OPW'($signed(cfg.b1));
            OPA_B0:   opa = OPW'($signed(cfg.b0));
            OPA_ABSD: opa = $signed(OPW'(dist_abs));
            OPA_MAG:  opa = $signed(OPW'(sp_abs));
            default:  opa = '0;
        endcase
    end

    always_comb
    begin
        case (ctrl.opb)
            OPB_UPREV: opb = OPW'(prev_out_reg[axis]);
            OPB_ERR:   opb = OPW'(dist_cm);
            OPB_EPREV: opb = OPW'(prev_err_reg[axis]);
            OPB_INV:   opb = $signed(OPW'(cfg.inv));
            OPB_MLO:   opb = $signed(OPW'(m_ext[ML-1:0]));
            OPB_MHI:   opb = $signed(OPW'(m_ext[MEXT_W-1:ML]));
            default:   opb = '0;
        endcase
    end

    // Multiply and align the product for the accumulator.
    assign prod = opa * opb;
    assign term = ACCW'(prod);

    always_comb
    begin
        case (ctrl.sh)
            SH_NONE: term_sh = term;
            SH_SIX:  term_sh = term <<< FB_SHIFT;
            SH_HALF: term_sh = term <<< ML;
            default: term_sh = term;
        endcase
    end

    // Filter output: round to the angle LSB, then clamp to the limit.
    assign acc_rnd = acc_reg + $signed(ACCW'(1) << (FRAC_W - 1));
    assign flt     = $signed(acc_rnd[ACCW-1:FRAC_W]);
    assign max_f   = FW'(cfg.max_ctl);
    assign lim     = (max_f > AMAX_F) ? AMAX_F : max_f;
    assign neg_lim = -lim;
    assign u_clamp = (flt > lim) ? lim : ((flt < neg_lim) ? neg_lim : flt);

    // Scaled setpoint magnitude: cap the product, then round off the ratio fraction.
    assign acc_u   = SATW'(acc_reg);
    assign mag_sat = (acc_u > MAG_CAP) ? MAG_CAP : acc_u;
    assign mag_rnd = mag_sat + (SATW'(1) << (FRAC_W - 1));

    // The setpoint is scaled when it is nonzero, the ratio is nonzero and it points the same way as the distance.
    assign scale_en = (m_reg != '0) && (sp != '0) && (sp[AW-1] == dist_cm[DW-1]);
    assign mag_ext  = $signed(SUMW'(mag_reg));
    assign scaled   = !scale_en ? SUMW'(sp) : (sp[AW-1] ? -mag_ext : mag_ext);
    assign sum_full = SUMW'(u_reg) + scaled;
    assign sum_sat  = (sum_full > $signed(AMAX_S)) ? AMAX_A :
                      ((sum_full < $signed(AMIN_S)) ? AMIN_A : sum_full[AW-1:0]);

    // Per-axis filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_out_reg[0] <= '0;
            prev_out_reg[1] <= '0;
            prev_err_reg[0] <= '0;
            prev_err_reg[1] <= '0;
        end
        else if (ctrl.fin)
        begin
            prev_out_reg[axis] <= u_clamp[AW-1:0];
            prev_err_reg[axis] <= dist_cm;
        end
    end

    // Accumulator and working registers.
    always_ff @(posedge clk)
    begin
        case (ctrl.acc_op)
            ACC_LOAD:     acc_reg <= term_sh;
            ACC_LOAD_NEG: acc_reg <= -term_sh;
            ACC_ADD:      acc_reg <= acc_reg + term_sh;
            default:      acc_reg <= acc_reg;
        endcase
        if (ctrl.fin)
        begin
            u_reg <= u_clamp[AW-1:0];
            m_reg <= MW'(prod);
        end
        if (ctrl.mag)
        begin
            mag_reg <= mag_rnd[SATW-1:FRAC_W];
        end
        if (ctrl.sum)
        begin
            res_reg[axis] <= sum_sat;
        end
    end

    assign pitch_res = res_reg[AXIS_PITCH];
    assign roll_res  = res_reg[AXIS_ROLL];

endmodule

// ===== hw/rtl/wall_avoid_lead_lag_controller.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wall_avoid_lead_lag_controller
// Lead-lag wall-avoidance filter for pitch and roll with setpoint scaling and
// saturation; yaw passes through.
// ============================================================================
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+----------------------------------
//  s_*      | in        | s_tvalid/s_tready  | setpoints and distance differences
//  m_*      | out       | m_tvalid/m_tready  | pitch, roll and yaw commands
//  cfg_*    | in        | cfg_write          | coefficient and limit registers
//
//  A transaction runs eight microcode steps per axis on one shared multiplier,
//  first for pitch and then for roll, then loads the output register in the
//  emit state; no new transaction is accepted until its result has been
//  loaded into the output register.
//  Reset clears the filter state and the configuration registers and leaves the block idle.
//  A stalled result waits in the output register; the next input is accepted
//  meanwhile and its result waits for the output register to free up.
//
module wall_avoid_lead_lag_controller
    import walc_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16,
    parameter int DIST_WIDTH  = 13
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0: pitch_setpoint, roll_setpoint, yaw_setpoint,
    // dist_diff_x, dist_diff_y, zero padding.
    input  logic [((3*ANGLE_WIDTH+2*DIST_WIDTH+7)/8)*8-1:0] s_tdata,
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0: pitch_out, roll_out, yaw_out, zero padding.
    output logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] m_tdata
);

    localparam int AW    = ANGLE_WIDTH;
    localparam int DW    = DIST_WIDTH;
    localparam int OUT_W = ((3 * AW + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   axis_reg, axis_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]       m_tdata_reg;
    cfg_t                   cfg_reg;
    logic signed [AW-1:0]   pitch_sp_reg;
    logic signed [AW-1:0]   roll_sp_reg;
    logic        [AW-1:0]   yaw_reg;
    logic signed [DW-1:0]   dx_reg;
    logic signed [DW-1:0]   dy_reg;
    logic                   load_in;
    logic                   emit;
    ctrl_t                  ctrl_rom;
    ctrl_t                  ctrl;
    logic signed [AW-1:0]   cur_sp;
    logic signed [DW-1:0]   cur_dist;
    logic [AW-1:0]          pitch_res;
    logic [AW-1:0]          roll_res;

    assign s_tready = (state_reg == ST_IDLE);
    assign load_in  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Microcode fetch; the datapath idles outside the run state.
    assign ctrl_rom = ucode_word(step_reg);
    assign ctrl     = (state_reg == ST_RUN) ? ctrl_rom : CTRL_NOP;

    // Sequencer: step counter with the per-axis loop jump.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        axis_next  = axis_reg;
        emit       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (load_in)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                    axis_next  = AXIS_PITCH;
                end
            end
            ST_RUN:
            begin
                if (ctrl_rom.jump == JMP_AXIS)
                begin
                    step_next = '0;
                    if (axis_reg == AXIS_PITCH)
                    begin
                        axis_next = AXIS_ROLL;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid tracks the pending transaction.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (emit)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            axis_reg     <= AXIS_PITCH;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            axis_reg     <= axis_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_COEF_A0:     cfg_reg.a0      <= cfg_data[A0_W-1:0];
                REG_COEF_B0:     cfg_reg.b0      <= cfg_data[COEF_W-1:0];
                REG_COEF_B1:     cfg_reg.b1      <= cfg_data[COEF_W-1:0];
                REG_MAX_CONTROL: cfg_reg.max_ctl <= cfg_data[MAXC_W-1:0];
                REG_INV_FREE:    cfg_reg.inv     <= cfg_data[INV_W-1:0];
                default:         cfg_reg         <= cfg_reg;
            endcase
        end
    end

    // Input capture and output load.
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            pitch_sp_reg <= s_tdata[AW-1:0];
            roll_sp_reg  <= s_tdata[2*AW-1:AW];
            yaw_reg      <= s_tdata[3*AW-1:2*AW];
            dx_reg       <= s_tdata[3*AW+DW-1:3*AW];
            dy_reg       <= s_tdata[3*AW+2*DW-1:3*AW+DW];
        end
        if (emit)
        begin
            m_tdata_reg <= OUT_W'({yaw_reg, roll_res, pitch_res});
        end
    end

    assign cur_sp   = (axis_reg == AXIS_ROLL) ? roll_sp_reg : pitch_sp_reg;
    assign cur_dist = (axis_reg == AXIS_ROLL) ? dy_reg : dx_reg;

    walc_datapath #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .DIST_WIDTH  (DIST_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .axis      (axis_reg),
        .cfg       (cfg_reg),
        .sp        (cur_sp),
        .dist_cm   (cur_dist),
        .pitch_res (pitch_res),
        .roll_res  (roll_res)
    );

endmodule

// ===== hw/rtl/walc_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// walc_checker
// Port-level checks of the wall-avoid controller, bound to the top level.
// ============================================================================
module walc_checker #(
    parameter int OUT_W = 48
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transaction changed while stalled");

    // One transaction at a time: input closes right after acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a transaction is in progress");

    // A new result appears only at the end of a transaction, while input is closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without a transaction in progress");

    // Input reopens only once the result has been posted.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_tready) |-> m_tvalid)
    else $error("input reopened without a posted result");

endmodule

bind wall_avoid_lead_lag_controller walc_checker #(
    .OUT_W (OUT_W)
) u_walc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
